FILE: rtl/core/fdsp_pkg.sv
// shared constants, codes and interface types of the factor dot-product sigmoid predictor
package fdsp_pkg;

   // default sizes of the factor stores
   localparam int DEF_MAX_USERS    = 1024;
   localparam int DEF_MAX_ITEMS    = 1024;
   localparam int DEF_MAX_CRITERIA = 4;
   localparam int DEF_MAX_FACTORS  = 16;

   // field widths
   localparam int VALUE_W    = 16;
   localparam int SCORE_W    = 16;
   localparam int MAG_W      = 16;
   localparam int CRIT_W     = 2;
   localparam int MODE_W     = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // request kinds carried on req_tuser
   localparam logic [MODE_W-1:0] MODE_WR_USER = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WR_ITEM = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PREDICT = 2'd2;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_FACTORS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITERIA = 2'd1;

   // register reset values
   localparam logic [4:0] FACTORS_RESET  = 5'd10;
   localparam logic [2:0] CRITERIA_RESET = 3'd1;

   // request to the sigmoid unit
   typedef struct packed {
      logic             start;
      logic             take;
      logic             neg;
      logic [MAG_W-1:0] mag;
   } sig_req_type;

   // answer of the sigmoid unit
   typedef struct packed {
      logic               valid;
      logic [SCORE_W-1:0] score;
   } sig_rsp_type;

   // index width for a dimension, at least one bit
   function automatic int idx_w(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

FILE: rtl/core/factor_dot_sigmoid_predictor_core.sv
// top level of the factor dot-product sigmoid predictor with its two factor stores
//
// Usage:
//   csr_*  : register writes (index 0 factors in use, index 1 criteria in use),
//            always ready, to be written only while the block is idle.
//   req_*  : one item per handshake. A load item (tuser 0 or 1) writes one
//            factor element. A predict item (tuser 2) starts a run of one
//            score per criterion in use.
//   rsp_*  : scores in criterion order, tlast on the final one of a run.
// Steps of a predict run, per criterion: a dot product over the user and
//   item stores, then the sigmoid unit, with one division by the term
//   number per series term and a final rounding division. The series
//   runs from 1 term (zero dot product) to about 38 terms at saturation.
// A new item is taken once the last score of a run sits in the output
// register, even while the receiver stalls it. A stalled score holds the
// next one inside the sigmoid unit. Reset clears control state and the
// registers; the factor stores hold nothing defined until written.
module factor_dot_sigmoid_predictor_core #(
   parameter int MAX_USERS    = fdsp_pkg::DEF_MAX_USERS,
   parameter int MAX_ITEMS    = fdsp_pkg::DEF_MAX_ITEMS,
   parameter int MAX_CRITERIA = fdsp_pkg::DEF_MAX_CRITERIA,
   parameter int MAX_FACTORS  = fdsp_pkg::DEF_MAX_FACTORS
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // user_index, item_index, criterion_index, factor_index, element_value, zero fill
   input  logic [fdsp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode
   input  logic [fdsp_pkg::MODE_W-1:0]         req_tuser,
   // result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // score
   output logic [fdsp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // score_criterion
   output logic [fdsp_pkg::CRIT_W-1:0]         rsp_tuser,
   output logic                                rsp_tlast,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fdsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fdsp_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int UW      = fdsp_pkg::idx_w(MAX_USERS);
   localparam int IW      = fdsp_pkg::idx_w(MAX_ITEMS);
   localparam int CW      = fdsp_pkg::idx_w(MAX_CRITERIA);
   localparam int FW      = fdsp_pkg::idx_w(MAX_FACTORS);
   localparam int NFW     = $clog2(MAX_FACTORS + 1);
   localparam int NC_MAX  = (MAX_CRITERIA < 4) ? MAX_CRITERIA : 4;
   localparam int NCW     = $clog2(NC_MAX + 1);
   localparam int UADR_W  = CW + UW + FW;
   localparam int IADR_W  = CW + IW + FW;
   localparam int UDEPTH  = 2 ** UADR_W;
   localparam int IDEPTH  = 2 ** IADR_W;
   localparam int ACC_W   = 32 + $clog2(MAX_FACTORS);
   localparam int VW      = fdsp_pkg::VALUE_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DOT  = 3'b010,
      ST_SIG  = 3'b100
   } ctl_state_type;

   // request fields
   logic [9:0]    req_user;
   logic [9:0]    req_item;
   logic [1:0]    req_crit;
   logic [3:0]    req_fac;
   logic [VW-1:0] req_value;

   assign req_user  = req_tdata[9:0];
   assign req_item  = req_tdata[19:10];
   assign req_crit  = req_tdata[21:20];
   assign req_fac   = req_tdata[25:22];
   assign req_value = req_tdata[41:26];

   ctl_state_type state_ff, state_in;

   logic [4:0]     factors_ff;
   logic [2:0]     criteria_ff;
   logic [CW-1:0]  crit_ff, crit_in;
   logic [NFW-1:0] issue_ff, issue_in;
   logic           rd_vld_ff;
   logic           prod_vld_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [UW-1:0]  user_ff;
   logic [IW-1:0]  item_ff;
   logic [NFW-1:0] nf_ff;
   logic [NCW-1:0] nc_ff;
   logic [NFW-1:0] nf_clamp;
   logic [NCW-1:0] nc_clamp;

   logic [VW-1:0]  user_mem [UDEPTH];
   logic [VW-1:0]  item_mem [IDEPTH];
   logic [VW-1:0]  user_rd_ff;
   logic [VW-1:0]  item_rd_ff;

   logic signed [31:0]    prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W:0]   acc_rnd;
   logic signed [ACC_W:0]   acc_q;
   logic [VW-1:0]           sat_val;

   logic [fdsp_pkg::CRIT_W-1:0]  rsp_crit_ff;
   logic [fdsp_pkg::SCORE_W-1:0] rsp_score_ff;
   logic                         rsp_last_ff;

   logic req_acc;
   logic user_wen;
   logic item_wen;
   logic pred_go;
   logic issue_go;
   logic dot_done;
   logic out_free;
   logic rsp_load;
   logic run_last;

   logic [UADR_W-1:0] user_waddr;
   logic [IADR_W-1:0] item_waddr;
   logic [UADR_W-1:0] user_raddr;
   logic [IADR_W-1:0] item_raddr;

   fdsp_pkg::sig_req_type sig_req;
   fdsp_pkg::sig_rsp_type sig_rsp;

   // item decode
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   assign user_wen = req_acc && (req_tuser == fdsp_pkg::MODE_WR_USER)
                     && (32'(req_user) < MAX_USERS) && (32'(req_crit) < MAX_CRITERIA)
                     && (32'(req_fac) < MAX_FACTORS);
   assign item_wen = req_acc && (req_tuser == fdsp_pkg::MODE_WR_ITEM)
                     && (32'(req_item) < MAX_ITEMS) && (32'(req_crit) < MAX_CRITERIA)
                     && (32'(req_fac) < MAX_FACTORS);
   assign pred_go  = req_acc && (req_tuser == fdsp_pkg::MODE_PREDICT)
                     && (32'(req_user) < MAX_USERS) && (32'(req_item) < MAX_ITEMS);

   // register limits, clamped at the start of a run
   always_comb begin
      if (factors_ff == '0) nf_clamp = NFW'(1);
      else if (32'(factors_ff) > MAX_FACTORS) nf_clamp = NFW'(MAX_FACTORS);
      else nf_clamp = NFW'(factors_ff);
      if (criteria_ff == '0) nc_clamp = NCW'(1);
      else if (32'(criteria_ff) > NC_MAX) nc_clamp = NCW'(NC_MAX);
      else nc_clamp = NCW'(criteria_ff);
   end

   // factor stores: element (criterion, row, factor)
   assign user_waddr = {CW'(req_crit), UW'(req_user), FW'(req_fac)};
   assign item_waddr = {CW'(req_crit), IW'(req_item), FW'(req_fac)};
   assign user_raddr = {crit_ff, user_ff, issue_ff[FW-1:0]};
   assign item_raddr = {crit_ff, item_ff, issue_ff[FW-1:0]};

   always_ff @(posedge clock) begin
      if (user_wen) user_mem[user_waddr] <= req_value;
      user_rd_ff <= user_mem[user_raddr];
   end

   always_ff @(posedge clock) begin
      if (item_wen) item_mem[item_waddr] <= req_value;
      item_rd_ff <= item_mem[item_raddr];
   end

   // run control
   assign issue_go = (state_ff == ST_DOT) && (issue_ff != nf_ff);
   assign dot_done = (state_ff == ST_DOT) && (issue_ff == nf_ff) && !rd_vld_ff && !prod_vld_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = (state_ff == ST_SIG) && sig_rsp.valid && out_free;
   assign run_last = ((NCW'(crit_ff) + NCW'(1)) == nc_ff);

   always_comb begin
      state_in = state_ff;
      crit_in  = crit_ff;
      issue_in = issue_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pred_go) begin
               state_in = ST_DOT;
               crit_in  = '0;
               issue_in = '0;
            end
         end
         ST_DOT: begin
            if (issue_go) issue_in = issue_ff + NFW'(1);
            if (dot_done) state_in = ST_SIG;
         end
         ST_SIG: begin
            if (rsp_load) begin
               if (run_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DOT;
                  crit_in  = crit_ff + CW'(1);
                  issue_in = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         crit_ff      <= '0;
         issue_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         factors_ff   <= fdsp_pkg::FACTORS_RESET;
         criteria_ff  <= fdsp_pkg::CRITERIA_RESET;
      end else begin
         state_ff     <= state_in;
         crit_ff      <= crit_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= issue_go;
         prod_vld_ff  <= rd_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fdsp_pkg::CSR_FACTORS:  factors_ff  <= csr_data[4:0];
               fdsp_pkg::CSR_CRITERIA: criteria_ff <= csr_data[2:0];
               default: ;
            endcase
         end
      end
   end

   assign csr_ready = 1'b1;

   // run parameters, products and the accumulator
   always_ff @(posedge clock) begin
      if (pred_go) begin
         user_ff <= UW'(req_user);
         item_ff <= IW'(req_item);
         nf_ff   <= nf_clamp;
         nc_ff   <= nc_clamp;
      end
      if (rd_vld_ff) prod_ff <= $signed(user_rd_ff) * $signed(item_rd_ff);
      if (pred_go || (rsp_load && !run_last)) acc_ff <= '0;
      else if (prod_vld_ff) acc_ff <= acc_ff + ACC_W'(prod_ff);
      if (rsp_load) begin
         rsp_crit_ff  <= fdsp_pkg::CRIT_W'(crit_ff);
         rsp_score_ff <= sig_rsp.score;
         rsp_last_ff  <= run_last;
      end
   end

   // round to q4.12 and saturate to the signed 16-bit range
   assign acc_rnd = {acc_ff[ACC_W-1], acc_ff} + (ACC_W + 1)'(2048);
   assign acc_q   = acc_rnd >>> 12;

   always_comb begin
      if (!acc_q[ACC_W] && (|acc_q[ACC_W-1:VW-1])) sat_val = {1'b0, {(VW - 1){1'b1}}};
      else if (acc_q[ACC_W] && !(&acc_q[ACC_W-1:VW-1])) sat_val = {1'b1, {(VW - 1){1'b0}}};
      else sat_val = acc_q[VW-1:0];
   end

   assign sig_req.start = dot_done;
   assign sig_req.take  = rsp_load;
   assign sig_req.neg   = sat_val[VW-1];
   assign sig_req.mag   = sat_val[VW-1] ? (~sat_val + VW'(1)) : sat_val;

   fdsp_sigmoid u_sigmoid (
      .clock   (clock),
      .reset   (reset),
      .sig_req (sig_req),
      .sig_rsp (sig_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_score_ff;
   assign rsp_tuser  = rsp_crit_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: rtl/core/fdsp_sigmoid.sv
// multi-cycle sigmoid unit: exponential series, then a bit-serial rounding division
module fdsp_sigmoid (
   input  logic                clock,
   input  logic                reset,
   input  fdsp_pkg::sig_req_type sig_req,
   output fdsp_pkg::sig_rsp_type sig_rsp
);

   localparam int TW        = 42;   // series term, below 2^41
   localparam int EW        = 44;   // series sum, below 2^44
   localparam int DW        = 45;   // denominator
   localparam int NW        = 61;   // rounded numerator
   localparam int HW        = 21;   // half of a term for the split multiply
   localparam int PW        = HW + fdsp_pkg::MAG_W;
   localparam int SW        = PW + HW + 1;
   localparam int XW        = 48;   // dividend of one term step
   localparam int QW        = 17;   // final quotient
   localparam int NMAX      = 48;
   localparam int DIV_STEPS = XW / 8;

   localparam logic [TW-1:0] ONE_T = TW'(33'h1_0000_0000);
   localparam logic [EW-1:0] ONE_E = EW'(33'h1_0000_0000);
   localparam logic [DW-1:0] ONE_D = DW'(33'h1_0000_0000);
   localparam logic [NW-1:0] ONE_N = NW'(49'h1_0000_0000_0000);

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_MLO   = 11'b000_0000_0010,
      S_MHI   = 11'b000_0000_0100,
      S_PREP  = 11'b000_0000_1000,
      S_DIV   = 11'b000_0001_0000,
      S_TERM  = 11'b000_0010_0000,
      S_FDEN  = 11'b000_0100_0000,
      S_FNUM  = 11'b000_1000_0000,
      S_FLOAD = 11'b001_0000_0000,
      S_FDIV  = 11'b010_0000_0000,
      S_DONE  = 11'b100_0000_0000
   } sig_state_type;

   sig_state_type state_ff, state_in;

   logic                      neg_ff;
   logic [fdsp_pkg::MAG_W-1:0] mag_ff;
   logic [TW-1:0]             t_ff;
   logic [EW-1:0]             e_ff;
   logic [5:0]                n_ff;
   logic [PW-1:0]             plo_ff;
   logic [PW-1:0]             phi_ff;
   logic [XW-1:0]             dq_ff;
   logic [5:0]                dr_ff;
   logic [2:0]                dcnt_ff;
   logic [DW-1:0]             den_ff;
   logic [NW-1:0]             fd_ff;
   logic [DW-1:0]             fr_ff;
   logic [QW-1:0]             fq_ff;
   logic [4:0]                fcnt_ff;

   logic [XW-1:0] dq_step;
   logic [5:0]    dr_step;
   logic [DW:0]   fr_wide;
   logic          fq_bit;
   logic [SW-1:0] prod_sum;
   logic [NW-1:0] num_sel;

   // eight quotient bits a cycle of the division by the term number
   always_comb begin
      logic [6:0] r7;
      dq_step = dq_ff;
      dr_step = dr_ff;
      for (int k = 0; k < 8; k++) begin
         r7      = {dr_step, dq_step[XW-1]};
         dq_step = {dq_step[XW-2:0], 1'b0};
         if (r7 >= {1'b0, n_ff}) begin
            r7         = r7 - {1'b0, n_ff};
            dq_step[0] = 1'b1;
         end
         dr_step = r7[5:0];
      end
   end

   // one quotient bit a cycle of the final rounding division
   always_comb begin
      fr_wide = {fr_ff, fq_ff[QW-1]};
      fq_bit  = 1'b0;
      if (fr_wide >= {1'b0, den_ff}) begin
         fr_wide = fr_wide - {1'b0, den_ff};
         fq_bit  = 1'b1;
      end
   end

   // term times magnitude from the two partial products, divided by 4096 in the prep step
   assign prod_sum = (SW'(phi_ff) << HW) + SW'(plo_ff);
   assign num_sel  = neg_ff ? ONE_N : (NW'(e_ff) << 16);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (sig_req.start) state_in = S_MLO;
         S_MLO:   state_in = S_MHI;
         S_MHI:   state_in = S_PREP;
         S_PREP:  state_in = S_DIV;
         S_DIV:   if (dcnt_ff == 3'(DIV_STEPS - 1)) state_in = S_TERM;
         S_TERM: begin
            if (dq_ff == '0 || n_ff == 6'(NMAX)) state_in = S_FDEN;
            else state_in = S_MLO;
         end
         S_FDEN:  state_in = S_FNUM;
         S_FNUM:  state_in = S_FLOAD;
         S_FLOAD: state_in = S_FDIV;
         S_FDIV:  if (fcnt_ff == 5'(QW - 1)) state_in = S_DONE;
         S_DONE:  if (sig_req.take) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            neg_ff <= sig_req.neg;
            mag_ff <= sig_req.mag;
            t_ff   <= ONE_T;
            e_ff   <= ONE_E;
            n_ff   <= 6'd1;
         end
         S_MLO:  plo_ff <= t_ff[HW-1:0] * mag_ff;
         S_MHI:  phi_ff <= t_ff[TW-1:HW] * mag_ff;
         S_PREP: begin
            dq_ff   <= XW'(prod_sum >> 12);
            dr_ff   <= '0;
            dcnt_ff <= '0;
         end
         S_DIV: begin
            dq_ff   <= dq_step;
            dr_ff   <= dr_step;
            dcnt_ff <= dcnt_ff + 3'd1;
         end
         S_TERM: begin
            e_ff <= e_ff + EW'(dq_ff);
            t_ff <= TW'(dq_ff);
            n_ff <= n_ff + 6'd1;
         end
         S_FDEN: den_ff <= DW'(e_ff) + ONE_D;
         S_FNUM: fd_ff <= num_sel + NW'(den_ff >> 1);
         S_FLOAD: begin
            fr_ff   <= DW'(fd_ff[NW-1:QW]);
            fq_ff   <= fd_ff[QW-1:0];
            fcnt_ff <= '0;
         end
         S_FDIV: begin
            fr_ff   <= fr_wide[DW-1:0];
            fq_ff   <= {fq_ff[QW-2:0], fq_bit};
            fcnt_ff <= fcnt_ff + 5'd1;
         end
         default: ;
      endcase
   end

   // score held until taken, capped at full scale
   assign sig_rsp.valid = (state_ff == S_DONE);
   assign sig_rsp.score = fq_ff[QW-1] ? '1 : fq_ff[QW-2:0];

endmodule

FILE: rtl/core/fdsp_checker.sv
// port checker of the predictor core and its bind
module fdsp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [fdsp_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [fdsp_pkg::MODE_W-1:0]     req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [fdsp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [fdsp_pkg::CRIT_W-1:0]     rsp_tuser,
   input logic                            rsp_tlast,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [fdsp_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [fdsp_pkg::CSR_DATA_W-1:0] csr_data
);

   // a stalled score holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled score changed");

   // no score straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("score valid after reset");

   // the fourth criterion always closes a run
   a_crit_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == 2'd3)) |-> rsp_tlast)
      else $error("fourth criterion not marked last");

   // within a run criteria follow in order
   a_crit_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast)
         |=> (!rsp_tvalid || (rsp_tuser == ($past(rsp_tuser) + 2'd1))))
      else $error("criterion out of order");

endmodule

bind factor_dot_sigmoid_predictor_core fdsp_checker u_checker (.*);

FILE: bench/tb.sv
// self-checking bench for the factor dot-product sigmoid predictor core
`timescale 1ns / 1ps

module tb;
   import fdsp_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int STORE_DEPTH  = DEF_MAX_CRITERIA * DEF_MAX_USERS * DEF_MAX_FACTORS;
   localparam int DRAIN_CYCLES = 30;
   localparam int QUIET_LIMIT  = 10000;
   localparam int HOLD_CYCLES  = 700;
   localparam int HOLD_AT      = 20;
   localparam int POOL_N       = 6;

   // one score as it leaves the block
   typedef struct packed {
      logic [CRIT_W-1:0]  crit;
      logic [SCORE_W-1:0] score;
      logic               last;
   } score_t;

   // mirror of the factor stores and registers, with the scores still owed
   class score_predictor;
      bit [VALUE_W-1:0] user_mem [STORE_DEPTH];
      bit [VALUE_W-1:0] item_mem [STORE_DEPTH];
      bit [4:0]         factors_reg  = FACTORS_RESET;
      bit [2:0]         criteria_reg = CRITERIA_RESET;
      score_t           expected_scores [$];
      int               errors;
      int               checked;

      function int elem_addr(int rows, int crit, int row, int fac);
         return (crit * rows + row) * DEF_MAX_FACTORS + fac;
      endfunction

      function int eff_factors();
         int n = factors_reg;
         if (n < 1) n = 1;
         if (n > DEF_MAX_FACTORS) n = DEF_MAX_FACTORS;
         return n;
      endfunction

      function int eff_criteria();
         int n = criteria_reg;
         if (n < 1) n = 1;
         if (n > DEF_MAX_CRITERIA) n = DEF_MAX_CRITERIA;
         if (n > 4) n = 4;
         return n;
      endfunction

      // round half up to q4.12 by floor shift, then saturate to [-8, 8)
      function int saturate_q412(longint acc);
         longint r;
         r = (acc + 2048) >>> 12;
         if (r > 32767) r = 32767;
         else if (r < -32768) r = -32768;
         return int'(r);
      endfunction

      // exp series in q.32, then the logistic ratio in q0.16
      function bit [SCORE_W-1:0] sigmoid_score(int s);
         longint unsigned unity, mag, series, term, num, den, q;
         unity  = 64'd1 << 32;
         mag    = (s < 0) ? -s : s;
         series = unity;
         term   = unity;
         for (int n = 1; n <= 48; n++) begin
            term = (term * mag) / (64'd4096 * n);
            if (term == 0) break;
            series += term;
         end
         den = series + unity;
         num = ((s < 0) ? unity : series) << 16;
         q   = (num + den / 2) / den;
         return (q > 65535) ? 16'hFFFF : q[15:0];
      endfunction

      function void note_csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_FACTORS) factors_reg = data[4:0];
         else if (idx == CSR_CRITERIA) criteria_reg = data[2:0];
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [9:0] user, logic [9:0] item,
                                 logic [1:0] crit, logic [3:0] fac, logic [15:0] value);
         int     nf, nc;
         longint acc;
         score_t want;
         case (mode)
            MODE_WR_USER: user_mem[elem_addr(DEF_MAX_USERS, crit, user, fac)] = value;
            MODE_WR_ITEM: item_mem[elem_addr(DEF_MAX_ITEMS, crit, item, fac)] = value;
            MODE_PREDICT: begin
               nf = eff_factors();
               nc = eff_criteria();
               // one score per criterion in use, in order
               for (int c = 0; c < nc; c++) begin
                  acc = 0;
                  for (int f = 0; f < nf; f++)
                     acc += longint'($signed(user_mem[elem_addr(DEF_MAX_USERS, c, user, f)]))
                          * longint'($signed(item_mem[elem_addr(DEF_MAX_ITEMS, c, item, f)]));
                  want.crit  = c[CRIT_W-1:0];
                  want.score = sigmoid_score(saturate_q412(acc));
                  want.last  = (c == nc - 1);
                  expected_scores.push_back(want);
               end
            end
            default: ;
         endcase
      endfunction

      task report(string what);
         errors++;
         $display("mismatch: %s", what);
      endtask

      task check_score(logic [CRIT_W-1:0] crit, logic [SCORE_W-1:0] score, logic last);
         score_t want;
         checked++;
         if (expected_scores.size() == 0) begin
            report($sformatf("score %0d arrived with none owed (crit %0d score %0d)",
                             checked, crit, score));
            return;
         end
         want = expected_scores.pop_front();
         if (crit !== want.crit)
            report($sformatf("score %0d: criterion %0d, want %0d", checked, crit, want.crit));
         if (score !== want.score)
            report($sformatf("score %0d: value %0d, want %0d", checked, score, want.score));
         if (last !== want.last)
            report($sformatf("score %0d: last %0b, want %0b", checked, last, want.last));
      endtask
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [MODE_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [CRIT_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   score_predictor sb = new();

   // elements written so far, so that no prediction reads an unwritten one
   bit user_set [STORE_DEPTH];
   bit item_set [STORE_DEPTH];

   int user_pool [POOL_N] = '{0, 1, 2, 3, 511, 1023};
   int item_pool [POOL_N] = '{0, 5, 6, 7, 512, 1023};

   int n_items, n_noise, n_pred, n_settings, rsp_count, hold_left, quiet;
   bit hold_done;

   factor_dot_sigmoid_predictor_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: random stalls, a stall-free stretch and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_score(rsp_tuser, rsp_tdata, rsp_tlast);
            rsp_count++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_count == HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (rsp_count >= 60 && rsp_count < 100) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 18);
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("watchdog: nothing moved for %0d cycles, %0d scores owed",
                  QUIET_LIMIT, sb.expected_scores.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [15:0] rand_value();
      int v;
      case ($urandom_range(0, 3))
         0: v = $urandom_range(0, 65535);
         1: v = $urandom_range(0, 4095) - 2048;
         2: begin
            case ($urandom_range(0, 3))
               0: v = 16'h8000;
               1: v = 16'h7FFF;
               2: v = 16'h0000;
               default: v = 16'hFFFF;
            endcase
         end
         default: v = $urandom_range(0, 16383) - 8192;
      endcase
      return v[15:0];
   endfunction

   // offer one item, leave valid high once it is taken
   task automatic send_item(logic [MODE_W-1:0] mode, logic [9:0] user, logic [9:0] item,
                            logic [1:0] crit, logic [3:0] fac, logic [15:0] value);
      if (!(n_items >= 150 && n_items < 260) && $urandom_range(0, 99) < 18) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'd0, value, fac, crit, item, user};
      do @(posedge clock); while (!req_tready);
      sb.note_request(mode, user, item, crit, fac, value);
      if (mode == MODE_UNUSED) n_noise++;
      else n_items++;
   endtask

   task automatic load_element(logic [MODE_W-1:0] mode, int row, int crit, int fac,
                               logic [15:0] value);
      int other;
      other = $urandom_range(0, 1023);
      if (mode == MODE_WR_USER) begin
         user_set[sb.elem_addr(DEF_MAX_USERS, crit, row, fac)] = 1'b1;
         send_item(mode, row, other, crit, fac, value);
      end else begin
         item_set[sb.elem_addr(DEF_MAX_ITEMS, crit, row, fac)] = 1'b1;
         send_item(mode, other, row, crit, fac, value);
      end
   endtask

   // fill whatever the pair still lacks under the current settings, then predict
   task automatic predict_pair(int user, int item);
      for (int c = 0; c < sb.eff_criteria(); c++)
         for (int f = 0; f < sb.eff_factors(); f++) begin
            if (!user_set[sb.elem_addr(DEF_MAX_USERS, c, user, f)])
               load_element(MODE_WR_USER, user, c, f, rand_value());
            if (!item_set[sb.elem_addr(DEF_MAX_ITEMS, c, item, f)])
               load_element(MODE_WR_ITEM, item, c, f, rand_value());
         end
      send_item(MODE_PREDICT, user, item, $urandom_range(0, 3), $urandom_range(0, 15),
                rand_value());
      n_pred++;
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.note_csr_write(idx, data);
   endtask

   task automatic wait_idle();
      while (sb.expected_scores.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // new register settings, only once the block has drained
   task automatic set_config(logic [CSR_DATA_W-1:0] fac_data, logic [CSR_DATA_W-1:0] crit_data);
      wait_idle();
      write_register(CSR_FACTORS, fac_data);
      write_register(CSR_CRITERIA, crit_data);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // mostly loads and predictions on a small pool, some stray loads and ignored items
   task automatic run_random_phase();
      int goal_items, goal_pred, sel;
      goal_items = n_items + 30;
      goal_pred  = n_pred + 8;
      while (n_items < goal_items || n_pred < goal_pred) begin
         sel = $urandom_range(0, 99);
         if (sel < 25)
            predict_pair(user_pool[$urandom_range(0, POOL_N - 1)],
                         item_pool[$urandom_range(0, POOL_N - 1)]);
         else if (sel < 50)
            load_element(MODE_WR_USER, user_pool[$urandom_range(0, POOL_N - 1)],
                         $urandom_range(0, 3), $urandom_range(0, 15), rand_value());
         else if (sel < 70)
            load_element(MODE_WR_ITEM, item_pool[$urandom_range(0, POOL_N - 1)],
                         $urandom_range(0, 3), $urandom_range(0, 15), rand_value());
         else if (sel < 88)
            load_element($urandom_range(0, 1) ? MODE_WR_ITEM : MODE_WR_USER,
                         $urandom_range(0, 1023), $urandom_range(0, 3),
                         $urandom_range(0, 15), rand_value());
         else
            send_item(MODE_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 3), $urandom_range(0, 15), rand_value());
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] fac_cfg  [6];
      logic [CSR_DATA_W-1:0] crit_cfg [6];
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: one factor, four criteria, upper register bits set
      set_config(8'hE1, 8'hFC);
      // saturation both ways, round half up, zero product
      load_element(MODE_WR_USER, 0, 0, 0, 16'h8000);
      load_element(MODE_WR_USER, 0, 1, 0, 16'h8000);
      load_element(MODE_WR_USER, 0, 2, 0, 16'h0001);
      load_element(MODE_WR_USER, 0, 3, 0, 16'h0000);
      load_element(MODE_WR_ITEM, 1023, 0, 0, 16'h8000);
      load_element(MODE_WR_ITEM, 1023, 1, 0, 16'h7FFF);
      load_element(MODE_WR_ITEM, 1023, 2, 0, 16'h0800);
      load_element(MODE_WR_ITEM, 1023, 3, 0, 16'h7FFF);
      predict_pair(0, 1023);
      // minus one against the same item: negative half rounds to zero
      for (int c = 0; c < 4; c++)
         load_element(MODE_WR_USER, 1023, c, 0, 16'hFFFF);
      predict_pair(1023, 1023);
      // unused mode with every field at its top
      send_item(MODE_UNUSED, 10'h3FF, 10'h3FF, 2'd3, 4'hF, 16'hFFFF);
      // last factor position, unused at one factor
      load_element(MODE_WR_USER, 0, 3, 15, 16'h7FFF);
      load_element(MODE_WR_ITEM, 0, 3, 15, 16'h8000);
      predict_pair(0, 1023);
      req_tvalid <= 1'b0;

      // register settings: both maxima, zero values, values past the maxima, reset, random
      fac_cfg  = '{8'h10, 8'h00, 8'hFF, 8'h0A, 8'h00, 8'h00};
      crit_cfg = '{8'h04, 8'hF8, 8'h07, 8'h01, 8'h00, 8'h00};
      for (int k = 0; k < 6; k++) begin
         if (k >= 4)
            set_config($urandom_range(0, 255), $urandom_range(0, 255));
         else
            set_config(fac_cfg[k], crit_cfg[k]);
         run_random_phase();
      end

      wait_idle();
      $display("covered %0d load and predict items (%0d predictions), %0d ignored items, %0d settings",
               n_items, n_pred, n_noise, n_settings);
      $display("%0d scores checked, receiver held off once for %0d cycles",
               sb.checked, HOLD_CYCLES);
      if (sb.errors == 0 && sb.expected_scores.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/fdsp_pkg.sv
rtl/core/fdsp_sigmoid.sv
rtl/core/factor_dot_sigmoid_predictor_core.sv
rtl/core/fdsp_checker.sv
bench/tb.sv
